/* hw/rtl/csal_pkg.sv */
package csal_pkg;

    // widths of the shared datapath
    localparam int unsigned DIV_W  = 42;
    localparam int unsigned DVS_W  = 19;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned ACC_W  = 55;
    localparam int unsigned MUL_W  = 18;
    localparam int unsigned CFG_IW = 3;

    localparam logic [CNT_W-1:0] LUX_ITERS = CNT_W'(42);
    localparam logic [CNT_W-1:0] CCT_ITERS = CNT_W'(32);
    localparam logic [19:0]      LUX_MAX   = 20'hFFFFF;
    localparam logic [15:0]      CCT_MAX   = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_COEF_R = 3'd0;
    localparam logic [CFG_IW-1:0] REG_COEF_G = 3'd1;
    localparam logic [CFG_IW-1:0] REG_COEF_B = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GLASS  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CCT_K  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_CCT_OF = 3'd5;

    typedef struct packed {
        logic [15:0] red_count;
        logic [15:0] green_count;
        logic [15:0] blue_count;
        logic [15:0] clear_count;
    } t_in;

    typedef struct packed {
        logic [1:0]  gain_code;
        logic [7:0]  atime_code;
        logic        result_valid;
        logic [16:0] infrared;
        logic [15:0] red_comp;
        logic [15:0] green_comp;
        logic [15:0] blue_comp;
        logic [15:0] clear_comp;
        logic        saturated;
        logic [19:0] lux_value;
        logic [15:0] color_temp;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_IR, ST_COMP, ST_M_R, ST_M_G, ST_M_B, ST_M_SUM,
        ST_L_LO, ST_L_HI, ST_L_ADD, ST_L_X10, ST_L_DIV, ST_L_WAIT,
        ST_C_MUL, ST_C_DIV, ST_C_WAIT, ST_FIN
    } t_state;

    // range table: gain code, atime, clear bounds (0 = none), lux divisor
    function automatic logic [1:0] range_gain(input logic [1:0] idx);
        case (idx)
            2'd0:    range_gain = 2'd3;
            2'd1:    range_gain = 2'd2;
            2'd2:    range_gain = 2'd1;
            default: range_gain = 2'd0;
        endcase
    endfunction

    function automatic logic [7:0] range_atime(input logic [1:0] idx);
        case (idx)
            2'd0:    range_atime = 8'h00;
            2'd1:    range_atime = 8'hC0;
            2'd2:    range_atime = 8'hC0;
            default: range_atime = 8'hFF;
        endcase
    endfunction

    function automatic logic [15:0] range_low(input logic [1:0] idx);
        case (idx)
            2'd0:    range_low = 16'd0;
            2'd1:    range_low = 16'd3171;
            2'd2:    range_low = 16'd15855;
            default: range_low = 16'd248;
        endcase
    endfunction

    function automatic logic [15:0] range_high(input logic [1:0] idx);
        case (idx)
            2'd0:    range_high = 16'd47566;
            2'd1:    range_high = 16'd63422;
            2'd2:    range_high = 16'd63422;
            default: range_high = 16'd0;
        endcase
    endfunction

    // tms * gain, the 4096 factor comes off the dividend
    function automatic logic [DVS_W-1:0] range_lux_div(input logic [1:0] idx);
        case (idx)
            2'd0:    range_lux_div = DVS_W'(368640);
            2'd1:    range_lux_div = DVS_W'(24576);
            2'd2:    range_lux_div = DVS_W'(6144);
            default: range_lux_div = DVS_W'(24);
        endcase
    endfunction

    // short integration only on the 2.4 ms range, 75% of 1024 counts
    function automatic logic range_sat(input logic [1:0] idx, input logic [15:0] clr);
        case (idx)
            2'd3:    range_sat = (clr > 16'd768);
            default: range_sat = 1'b0;
        endcase
    endfunction

endpackage

/* hw/rtl/csal_div.sv */
module csal_div import csal_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // restoring step, one quotient bit per cycle
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_done <= 1'b0;
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                r_quo  <= {r_quo[DIV_W-2:0], ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* hw/rtl/color_sensor_autorange_lux.sv */
// an item passes more states when lux and colour temperature are both worked out than when
// either is skipped, and fewest when the range moves; an output stall holds it in ST_FIN
// throughput: one item at a time, none taken until the last leaves ST_FIN; the divider runs
// one bit per cycle, for lux (42 steps) and colour temperature (32 steps) when needed, besides
// the shared multiplier steps; reset: range index 0 (60x), no skipped check, coefficients at
// defaults, output register empty
module color_sensor_autorange_lux import csal_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    t_state r_state, n_state;

    logic [15:0] r_cr, r_cg, r_cb, r_glass, r_cctk, r_cctof;
    logic [1:0]  r_idx;
    logic        r_skip;
    t_in         r_in;
    t_out        r_res;
    t_out        r_out;
    logic        r_out_valid;
    logic [16:0] r_ir;
    logic [32:0] r_s;
    logic signed [35:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [35:0]      mul_p;
    logic signed [ACC_W-1:0] prod_ext;
    logic [17:0] rgb_sum;
    logic        go_up, go_down, out_free, s_pos;
    logic [1:0]  idx_up, idx_down;
    logic [32:0] cct_sum;
    t_out        chk_res;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || !i_stall;

    // range check
    assign go_up    = (range_high(r_idx) != 16'd0) && (r_in.clear_count > range_high(r_idx));
    assign go_down  = (range_low(r_idx) != 16'd0) && (r_in.clear_count < range_low(r_idx));
    assign idx_up   = r_idx + 2'd1;
    assign idx_down = r_idx - 2'd1;
    assign rgb_sum  = 18'(r_in.red_count) + 18'(r_in.green_count) + 18'(r_in.blue_count);
    assign s_pos    = !r_acc[ACC_W-1] && (r_acc != '0);
    assign prod_ext = ACC_W'(r_prod);
    assign cct_sum  = 33'(div_rsp.quotient[31:0]) + 33'(r_cctof);

    // result fields settled by the range check
    always_comb begin
        chk_res = '0;
        if (!r_skip && go_up) begin
            chk_res.gain_code  = range_gain(idx_up);
            chk_res.atime_code = range_atime(idx_up);
        end else if (!r_skip && go_down) begin
            chk_res.gain_code  = range_gain(idx_down);
            chk_res.atime_code = range_atime(idx_down);
        end else begin
            chk_res.gain_code    = range_gain(r_idx);
            chk_res.atime_code   = range_atime(r_idx);
            chk_res.result_valid = 1'b1;
            chk_res.saturated    = range_sat(r_idx, r_in.clear_count);
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_M_R: begin
                mul_a = MUL_W'(signed'(r_cr));
                mul_b = signed'({2'b0, r_res.red_comp});
            end
            ST_M_G: begin
                mul_a = MUL_W'(signed'(r_cg));
                mul_b = signed'({2'b0, r_res.green_comp});
            end
            ST_M_B: begin
                mul_a = MUL_W'(signed'(r_cb));
                mul_b = signed'({2'b0, r_res.blue_comp});
            end
            ST_L_LO: begin
                mul_a = signed'({1'b0, r_acc[16:0]});
                mul_b = signed'({2'b0, r_glass});
            end
            ST_L_HI: begin
                mul_a = signed'({2'b0, r_s[32:17]});
                mul_b = signed'({2'b0, r_glass});
            end
            ST_C_MUL: begin
                mul_a = signed'({2'b0, r_cctk});
                mul_b = signed'({2'b0, r_res.blue_comp});
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and divider requests
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.iters    = LUX_ITERS;
        div_req.dividend = r_acc[53:12];
        div_req.divisor  = range_lux_div(r_idx);
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_CHECK;
            ST_CHECK:  n_state = (!r_skip && (go_up || go_down)) ? ST_FIN : ST_IR;
            ST_IR:     n_state = ST_COMP;
            ST_COMP:   n_state = ST_M_R;
            ST_M_R:    n_state = ST_M_G;
            ST_M_G:    n_state = ST_M_B;
            ST_M_B:    n_state = ST_M_SUM;
            ST_M_SUM:  n_state = ST_L_LO;
            ST_L_LO:   n_state = s_pos ? ST_L_HI : ST_C_MUL;
            ST_L_HI:   n_state = ST_L_ADD;
            ST_L_ADD:  n_state = ST_L_X10;
            ST_L_X10:  n_state = ST_L_DIV;
            ST_L_DIV: begin
                div_req.start = 1'b1;
                n_state       = ST_L_WAIT;
            end
            ST_L_WAIT: if (div_rsp.done) n_state = ST_C_MUL;
            ST_C_MUL:  n_state = ST_C_DIV;
            ST_C_DIV: begin
                if (r_res.red_comp == 16'd0) begin
                    n_state = ST_FIN;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.iters    = CCT_ITERS;
                    div_req.dividend = {r_prod[31:0], 10'b0};
                    div_req.divisor  = DVS_W'(r_res.red_comp);
                    n_state          = ST_C_WAIT;
                end
            end
            ST_C_WAIT: if (div_rsp.done) n_state = ST_FIN;
            ST_FIN:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // configuration registers and range state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr    <= 16'd557;
            r_cg    <= 16'd4096;
            r_cb    <= 16'(-16'sd1819);
            r_glass <= 16'd4960;
            r_cctk  <= 16'd3810;
            r_cctof <= 16'd1391;
            r_idx   <= 2'd0;
            r_skip  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_COEF_R: r_cr    <= i_cfg_data;
                    REG_COEF_G: r_cg    <= i_cfg_data;
                    REG_COEF_B: r_cb    <= i_cfg_data;
                    REG_GLASS:  r_glass <= i_cfg_data;
                    REG_CCT_K:  r_cctk  <= i_cfg_data;
                    REG_CCT_OF: r_cctof <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_CHECK) begin
                if (r_skip) begin
                    r_skip <= 1'b0;
                end else if (go_up) begin
                    r_idx  <= idx_up;
                    r_skip <= 1'b1;
                end else if (go_down) begin
                    r_idx  <= idx_down;
                    r_skip <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: if (i_valid) r_in <= i_in;
            ST_CHECK: begin
                r_res <= chk_res;
                r_ir  <= (rgb_sum > 18'(r_in.clear_count))
                       ? 17'((rgb_sum - 18'(r_in.clear_count)) >> 1) : 17'd0;
            end
            ST_IR: r_res.infrared <= r_ir;
            ST_COMP: begin
                r_res.red_comp   <= (17'(r_in.red_count) > r_ir)
                                  ? 16'(17'(r_in.red_count) - r_ir) : 16'd0;
                r_res.green_comp <= (17'(r_in.green_count) > r_ir)
                                  ? 16'(17'(r_in.green_count) - r_ir) : 16'd0;
                r_res.blue_comp  <= (17'(r_in.blue_count) > r_ir)
                                  ? 16'(17'(r_in.blue_count) - r_ir) : 16'd0;
                r_res.clear_comp <= (17'(r_in.clear_count) > r_ir)
                                  ? 16'(17'(r_in.clear_count) - r_ir) : 16'd0;
            end
            ST_M_G:   r_acc <= prod_ext;
            ST_M_B:   r_acc <= r_acc + prod_ext;
            ST_M_SUM: r_acc <= r_acc + prod_ext;
            ST_L_LO:  r_s   <= r_acc[32:0];
            ST_L_HI:  r_acc <= prod_ext;
            ST_L_ADD: r_acc <= r_acc + (prod_ext <<< 17);
            ST_L_X10: r_acc <= (r_acc <<< 3) + (r_acc <<< 1);
            ST_L_WAIT: begin
                if (div_rsp.done) begin
                    r_res.lux_value <= (div_rsp.quotient > DIV_W'(LUX_MAX))
                                     ? LUX_MAX : div_rsp.quotient[19:0];
                end
            end
            ST_C_DIV: if (r_res.red_comp == 16'd0) r_res.color_temp <= CCT_MAX;
            ST_C_WAIT: begin
                if (div_rsp.done) begin
                    r_res.color_temp <= (div_rsp.quotient[DIV_W-1:32] != '0 ||
                                         cct_sum > 33'(CCT_MAX))
                                      ? CCT_MAX : cct_sum[15:0];
                end
            end
            default: ;
        endcase
    end

    // output register, takes a result when empty or when the sink takes the last in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
            r_out       <= r_res;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    csal_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // range index only moves during the check
    a_idx_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_idx) |-> $past(r_state) == ST_CHECK)
        else $error("range index moved outside check");

    // divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_L_WAIT || r_state == ST_C_WAIT))
        else $error("divider done while not waited on");

    // a range change result carries no measurement
    a_discard_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.result_valid) |->
            (o_out.lux_value == 20'd0 && o_out.infrared == 17'd0 &&
             o_out.color_temp == 16'd0))
        else $error("discard result carries data");

    // zero red gives saturated colour temperature
    a_cct_red0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.result_valid && o_out.red_comp == 16'd0) |->
            o_out.color_temp == CCT_MAX)
        else $error("colour temperature wrong for zero red");

endmodule
